// ===== rtl/mtep_pkg.sv =====
package mtep_pkg;

  localparam int QTY_W  = 28;
  localparam int CNT_W  = 3;

  localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
  localparam logic [7:0] STATUS_META   = 8'hFF;
  localparam logic [3:0] CLASS_PROGRAM = 4'hC;
  localparam logic [3:0] CLASS_CHAN_PR = 4'hD;

  typedef enum logic [1:0] {
    KIND_CHANNEL,
    KIND_HEADER,
    KIND_PAYLOAD,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_NO_RUNNING,
    ERR_TRUNCATED
  } err_t;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
    logic       track_end;
  } byte_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [QTY_W-1:0] delta_time;
    logic [7:0]       status;
    logic [7:0]       first_data;
    logic [7:0]       second_data;
    logic [QTY_W-1:0] payload_length;
    logic             last_of_event;
    logic             more_in_track;
    err_t             error_code;
  } result_t;

  typedef struct packed {
    phase_t           phase;
    logic [7:0]       running_status;
    logic [7:0]       current_status;
    logic [QTY_W-1:0] delta_acc;
    logic [CNT_W-1:0] qty_seen;
    logic [7:0]       held_first;
    logic [QTY_W-1:0] length_acc;
    logic [QTY_W-1:0] payload_left;
  } parse_state_t;

endpackage

// ===== rtl/mtep_byte_if.sv =====
interface mtep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;
  logic       track_end;

  modport source (output valid, data_byte, track_start, track_end, input ready);
  modport sink   (input valid, data_byte, track_start, track_end, output ready);
endinterface

// ===== rtl/mtep_event_if.sv =====
interface mtep_event_if;
  logic                        valid;
  logic                        ready;
  mtep_pkg::kind_t             kind;
  logic [mtep_pkg::QTY_W-1:0]  delta_time;
  logic [7:0]                  status;
  logic [7:0]                  first_data;
  logic [7:0]                  second_data;
  logic [mtep_pkg::QTY_W-1:0]  payload_length;
  logic                        last_of_event;
  logic                        more_in_track;
  mtep_pkg::err_t              error_code;

  modport source (output valid, kind, delta_time, status, first_data, second_data,
                  payload_length, last_of_event, more_in_track, error_code,
                  input ready);
  modport sink   (input valid, kind, delta_time, status, first_data, second_data,
                  payload_length, last_of_event, more_in_track, error_code,
                  output ready);
endinterface

// ===== rtl/mtep_core.sv =====
module mtep_core #(
  parameter int MAX_QUANTITY_BYTES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  mtep_pkg::byte_item_t item,
  output logic                 has_result,
  output mtep_pkg::result_t    result
);
  import mtep_pkg::*;

  localparam logic [CNT_W-1:0] MAX_Q = CNT_W'(MAX_QUANTITY_BYTES);

  parse_state_t     state;
  parse_state_t     state_next;
  logic [7:0]       b;
  logic             more;
  logic             done;
  logic             ignoring;
  logic             qty_last;
  logic [CNT_W-1:0] qty_count;

  assign b    = item.data_byte;
  assign more = ~item.track_end;

  // Seven new bits per byte of a variable-length quantity, top bits drop off.
  function automatic logic [QTY_W-1:0] qty_shift(input logic [QTY_W-1:0] acc,
                                                 input logic [7:0] d);
    qty_shift = {acc[QTY_W-8:0], d[6:0]};
  endfunction

  always_comb begin
    state_next = state;
    if (item.track_start) begin
      state_next                = '0;
      state_next.phase          = PH_DELTA;
    end
    ignoring   = (state_next.phase == PH_HALT);
    done       = 1'b0;
    has_result = 1'b0;
    result     = '0;
    qty_count  = state_next.qty_seen + CNT_W'(1);
    qty_last   = ~b[7] || (qty_count >= MAX_Q);

    case (state_next.phase)
      PH_DELTA: begin
        state_next.delta_acc = qty_shift(state_next.delta_acc, b);
        state_next.qty_seen  = qty_count;
        if (qty_last) begin
          state_next.qty_seen = '0;
          state_next.phase    = PH_STATUS;
        end
      end
      PH_STATUS, PH_DATA1: begin
        if (state_next.phase == PH_STATUS && b[7]) begin
          state_next.current_status = b;
          state_next.held_first     = '0;
          state_next.length_acc     = '0;
          state_next.qty_seen       = '0;
          if (b < STATUS_SYSTEM) begin
            state_next.running_status = b;
            state_next.phase          = PH_DATA1;
          end else begin
            state_next.running_status = '0;
            state_next.phase = (b == STATUS_META) ? PH_META : PH_LENGTH;
          end
        end else if (state_next.phase == PH_STATUS && state_next.running_status == 8'd0) begin
          has_result           = 1'b1;
          result.kind          = KIND_ERROR;
          result.first_data    = b;
          result.last_of_event = 1'b1;
          result.more_in_track = more;
          result.error_code    = ERR_NO_RUNNING;
          done                 = 1'b1;
          state_next.phase     = PH_HALT;
        end else begin
          if (state_next.phase == PH_STATUS) begin
            state_next.current_status = state_next.running_status;
          end
          if (state_next.current_status[7:4] inside {CLASS_PROGRAM, CLASS_CHAN_PR}) begin
            has_result           = 1'b1;
            result.kind          = KIND_CHANNEL;
            result.first_data    = b;
            result.last_of_event = 1'b1;
            result.more_in_track = more;
            done                 = 1'b1;
          end else begin
            state_next.held_first = b;
            state_next.phase      = PH_DATA2;
          end
        end
      end
      PH_DATA2: begin
        has_result           = 1'b1;
        result.kind          = KIND_CHANNEL;
        result.first_data    = state_next.held_first;
        result.second_data   = b;
        result.last_of_event = 1'b1;
        result.more_in_track = more;
        done                 = 1'b1;
      end
      PH_META: begin
        state_next.held_first = b;
        state_next.qty_seen   = '0;
        state_next.phase      = PH_LENGTH;
      end
      PH_LENGTH: begin
        state_next.length_acc = qty_shift(state_next.length_acc, b);
        state_next.qty_seen   = qty_count;
        if (qty_last) begin
          state_next.qty_seen  = '0;
          has_result           = 1'b1;
          result.kind          = KIND_HEADER;
          result.first_data    = state_next.held_first;
          result.more_in_track = more;
          if (state_next.length_acc == '0) begin
            result.last_of_event = 1'b1;
            done                 = 1'b1;
          end else begin
            result.payload_length   = state_next.length_acc;
            state_next.payload_left = state_next.length_acc;
            state_next.phase        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        state_next.payload_left = state_next.payload_left - QTY_W'(1);
        done                    = (state_next.payload_left == '0);
        has_result              = 1'b1;
        result.kind             = KIND_PAYLOAD;
        result.first_data       = b;
        result.payload_length   = state_next.length_acc;
        result.last_of_event    = done;
        result.more_in_track    = more;
      end
      default: begin
      end
    endcase

    if (item.track_end && !done && !ignoring) begin
      has_result           = 1'b1;
      result               = '0;
      result.kind          = KIND_ERROR;
      result.first_data    = b;
      result.last_of_event = 1'b1;
      result.error_code    = ERR_TRUNCATED;
    end
    result.delta_time = state_next.delta_acc;
    result.status     = state_next.current_status;

    if ((done && state_next.phase != PH_HALT) || item.track_end) begin
      state_next.phase          = PH_DELTA;
      state_next.current_status = '0;
      state_next.delta_acc      = '0;
      state_next.qty_seen       = '0;
      state_next.held_first     = '0;
      state_next.length_acc     = '0;
      state_next.payload_left   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= '0;
      state.phase <= PH_DELTA;
    end else if (fire) begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/midi_track_event_parser.sv =====
// A byte accepted into the input register gives its result item through the
// result register. One track byte per cycle is taken while the sink does not
// stall, with at most one result item per byte; the single parse step between
// the registers sets the rate. Reset (synchronous, active high) empties both
// registers, puts the parser in the delta-time phase and clears running status.
module midi_track_event_parser #(
  parameter int MAX_QUANTITY_BYTES = 4
) (
  input logic          clk,
  input logic          rst,
  mtep_byte_if.sink    track,
  mtep_event_if.source events
);
  import mtep_pkg::*;

  // Input register: holds one byte item until the parse step can consume it.
  logic       in_valid;
  byte_item_t in_item;

  // Result register: the parse step writes here; the sink drains it.
  logic       out_valid;
  result_t    out_item;

  logic       advance;
  logic       has_result;
  result_t    result;

  // The held byte is parsed when the result register is free or is being
  // emptied in this same cycle, so a byte moves on every cycle in steady flow.
  assign advance     = in_valid && (!out_valid || events.ready);
  assign track.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (track.ready) begin
      in_valid <= track.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (track.valid && track.ready) begin
      in_item.data_byte   <= track.data_byte;
      in_item.track_start <= track.track_start;
      in_item.track_end   <= track.track_end;
    end
  end

  // The parser state lives in the core; it moves one step per consumed byte.
  mtep_core #(
    .MAX_QUANTITY_BYTES(MAX_QUANTITY_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (in_item),
    .has_result(has_result),
    .result    (result)
  );

  // Bytes that only feed the parser state (delta-time bytes, status bytes,
  // first data bytes of two-byte messages) produce no item and leave the
  // result register empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_item <= result;
    end
  end

  assign events.valid          = out_valid;
  assign events.kind           = out_item.kind;
  assign events.delta_time     = out_item.delta_time;
  assign events.status         = out_item.status;
  assign events.first_data     = out_item.first_data;
  assign events.second_data    = out_item.second_data;
  assign events.payload_length = out_item.payload_length;
  assign events.last_of_event  = out_item.last_of_event;
  assign events.more_in_track  = out_item.more_in_track;
  assign events.error_code     = out_item.error_code;

  // An accepted byte is always held for the parse step in the next cycle.
  a_in_held: assert property (@(posedge clk) disable iff (rst)
    track.valid && track.ready |=> in_valid)
    else $error("accepted byte was not held in the input register");

  // Error items and only error items carry an error code.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.kind == KIND_ERROR) == (out_item.error_code != ERR_NONE)))
    else $error("error code does not match item kind");

  // Every error closes its event.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_ERROR |-> out_item.last_of_event)
    else $error("error item not marked last of event");

  // A payload byte always belongs to an event with a nonzero length.
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_PAYLOAD |-> out_item.payload_length != '0)
    else $error("payload byte with zero payload length");

  // A result register that is full and stalled blocks the parse step.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !events.ready |-> !advance)
    else $error("parse step overwrote a pending result");

endmodule
